// ----- src/ultrasonic_range_averager_top_defines.svh -----
// Assertion macros shared by the range averager RTL.
`ifndef ULTRASONIC_RANGE_AVERAGER_TOP_DEFINES_SVH
`define ULTRASONIC_RANGE_AVERAGER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define URAV_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define URAV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/urav_pkg.sv -----
// Shared types and constants of the ultrasonic range averager.
package urav_pkg;

   // divider operand widths: sum*100000 needs 41 bits, valid*147828 needs 26
   localparam int NUM_W = 41;
   localparam int DEN_W = 26;
   localparam int CNT_W = $clog2(NUM_W + 1);

   localparam int SUM_W  = 24;
   localparam int PW_W   = 16;
   localparam int DIST_W = 17;
   localparam int ADDR_W = 4;

   localparam int unsigned CM_SCALE       = 1000;
   localparam int unsigned CM_DIV         = 582;
   localparam int unsigned INCH_SCALE     = 100000;
   localparam int unsigned INCH_DIV       = 147828;
   localparam int unsigned DIST_MAX       = 131071;
   localparam int unsigned TICKS_PER_MS   = 1000;
   localparam int unsigned TRIG_LOW_TICKS = 2;

   typedef enum logic [1:0] {
      REG_SAMPLE_COUNT,
      REG_SAMPLE_GAP_MS,
      REG_UNIT_INCH,
      REG_THRESHOLD
   } reg_index_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ----- src/ultrasonic_range_averager_top.sv -----
// Ultrasonic range averager. Each input word is one microsecond tick carrying a start
// request and the sampled echo level; each tick returns exactly one result word with the
// trigger level, busy/done flags and, on the done tick, the averaged distance. An ordinary
// tick's result word is registered as the tick is taken. The tick that ends a run with at least one
// valid echo runs two constant multiplies and a 41-step restoring division in one shared
// divider for centimeters; inches add a second pair of multiplies and a second division.
// No new tick is accepted until that result is in the output register. Results wait in a
// one-word output register; a new tick is accepted in the same cycle that word is taken.
// Configuration registers sit at byte addresses 0 (sample_count), 4 (sample_gap_ms),
// 8 (unit_inch) and 12 (threshold_centi_cm) and read back their values.
`include "ultrasonic_range_averager_top_defines.svh"

module ultrasonic_range_averager_top #(
   parameter int ECHO_TIMEOUT_US = 50000,
   parameter int TRIGGER_HIGH_US = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   // request: [0] start_req, [1] echo_level
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,
   // response: [0] trigger_level, [1] busy_res, [2] done_res, [19:3] distance_centi,
   // [20] no_echo, [21] detected, [29:22] valid_samples
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [31:0]                 rsp_tdata,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [urav_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   localparam int TICK_W = $clog2(ECHO_TIMEOUT_US + 1);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_TRIG_LOW,
      PH_TRIG_HIGH,
      PH_WAIT_LOW,
      PH_WAIT_HIGH,
      PH_PULSE,
      PH_GAP
   } phase_type;

   typedef enum logic [2:0] {
      SQ_IDLE,
      SQ_NUM_CM,
      SQ_DEN_CM,
      SQ_DIV_CM,
      SQ_NUM_IN,
      SQ_DEN_IN,
      SQ_DIV_IN
   } seq_type;

   // configuration
   logic [7:0]                  cfg_count_ff;
   logic [15:0]                 cfg_gap_ff;
   logic                        cfg_inch_ff;
   logic [urav_pkg::DIST_W-1:0] cfg_thresh_ff;
   logic                        csr_write;
   urav_pkg::reg_index_type     csr_index;

   // measurement state
   phase_type                   phase_ff, phase_in;
   logic [TICK_W-1:0]           tick_ff, tick_in;
   logic [15:0]                 gap_ff, gap_in;
   logic [urav_pkg::PW_W-1:0]   pw_ff, pw_in;
   logic [7:0]                  sdone_ff, sdone_in;
   logic [7:0]                  vcnt_ff, vcnt_in;
   logic [urav_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic                        tk_trig;
   logic                        tk_end;
   logic                        meas_done;
   logic                        meas_ok;

   // sequencer, divider and output register
   seq_type                     seq_ff;
   logic                        div_start_ff;
   logic [urav_pkg::NUM_W-1:0]  num_op_ff;
   logic [urav_pkg::DEN_W-1:0]  den_op_ff;
   logic [urav_pkg::NUM_W-1:0]  div_q;
   urav_pkg::div_status_type    div_stat;
   logic                        det_ff;
   logic [urav_pkg::DIST_W-1:0] dist_sat;
   logic                        q_le_thresh;
   logic                        rsp_tvalid_ff;
   logic [31:0]                 rsp_tdata_ff;
   logic                        req_accept;
   logic                        start_req;
   logic                        echo_level;

   assign start_req  = req_tdata[0];
   assign echo_level = req_tdata[1];
   assign req_tready = (seq_ff == SQ_IDLE) && (!rsp_tvalid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = urav_pkg::reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_count_ff  <= 8'd1;
         cfg_gap_ff    <= '0;
         cfg_inch_ff   <= 1'b0;
         cfg_thresh_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            urav_pkg::REG_SAMPLE_COUNT:  cfg_count_ff  <= csr_pwdata[7:0];
            urav_pkg::REG_SAMPLE_GAP_MS: cfg_gap_ff    <= csr_pwdata[15:0];
            urav_pkg::REG_UNIT_INCH:     cfg_inch_ff   <= csr_pwdata[0];
            urav_pkg::REG_THRESHOLD:     cfg_thresh_ff <= csr_pwdata[urav_pkg::DIST_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         urav_pkg::REG_SAMPLE_COUNT:  csr_prdata = {24'd0, cfg_count_ff};
         urav_pkg::REG_SAMPLE_GAP_MS: csr_prdata = {16'd0, cfg_gap_ff};
         urav_pkg::REG_UNIT_INCH:     csr_prdata = {31'd0, cfg_inch_ff};
         urav_pkg::REG_THRESHOLD:     csr_prdata = {15'd0, cfg_thresh_ff};
         default:                     csr_prdata = '0;
      endcase
   end

   // one tick of the measurement sequence
   always_comb begin
      phase_in  = phase_ff;
      tick_in   = tick_ff;
      gap_in    = gap_ff;
      pw_in     = pw_ff;
      sdone_in  = sdone_ff;
      vcnt_in   = vcnt_ff;
      sum_in    = sum_ff;
      tk_trig   = 1'b0;
      tk_end    = 1'b0;
      meas_done = 1'b0;
      meas_ok   = 1'b0;

      if (phase_ff == PH_IDLE && start_req) begin
         sdone_in = '0;
         vcnt_in  = '0;
         sum_in   = '0;
         pw_in    = '0;
         tick_in  = '0;
         gap_in   = '0;
         if (cfg_count_ff == 8'd0) begin
            tk_end = 1'b1;
         end else begin
            phase_in = PH_TRIG_LOW;
         end
      end

      case (phase_in)
         PH_TRIG_LOW: begin
            tick_in = tick_in + TICK_W'(1);
            if (tick_in >= TICK_W'(urav_pkg::TRIG_LOW_TICKS)) begin
               phase_in = PH_TRIG_HIGH;
               tick_in  = '0;
            end
         end
         PH_TRIG_HIGH: begin
            tk_trig = 1'b1;
            tick_in = tick_in + TICK_W'(1);
            if (tick_in >= TICK_W'(TRIGGER_HIGH_US)) begin
               phase_in = PH_WAIT_LOW;
               tick_in  = '0;
            end
         end
         PH_WAIT_LOW, PH_WAIT_HIGH, PH_PULSE: begin
            tick_in = tick_in + TICK_W'(1);
            if (phase_in == PH_WAIT_LOW) begin
               // let an echo already in flight end first
               if (!echo_level) phase_in = PH_WAIT_HIGH;
            end else if (phase_in == PH_WAIT_HIGH) begin
               if (echo_level) begin
                  phase_in = PH_PULSE;
                  pw_in    = urav_pkg::PW_W'(1);
               end
            end else if (echo_level) begin
               if (pw_in != '1) pw_in = pw_in + urav_pkg::PW_W'(1);
            end else begin
               meas_done = 1'b1;
               meas_ok   = 1'b1;
            end
            if (!meas_done && tick_in >= TICK_W'(ECHO_TIMEOUT_US)) meas_done = 1'b1;
            if (meas_done) begin
               sdone_in = sdone_in + 8'd1;
               if (meas_ok) begin
                  vcnt_in = vcnt_in + 8'd1;
                  sum_in  = sum_in + urav_pkg::SUM_W'(pw_in);
               end
               pw_in   = '0;
               tick_in = '0;
               gap_in  = '0;
               if (cfg_gap_ff == 16'd0) begin
                  if (sdone_in >= cfg_count_ff) begin
                     phase_in = PH_IDLE;
                     tk_end   = 1'b1;
                  end else begin
                     phase_in = PH_TRIG_LOW;
                  end
               end else begin
                  phase_in = PH_GAP;
               end
            end
         end
         PH_GAP: begin
            tick_in = tick_in + TICK_W'(1);
            if (tick_in >= TICK_W'(urav_pkg::TICKS_PER_MS)) begin
               tick_in = '0;
               if (gap_in != '1) gap_in = gap_in + 16'd1;
            end
            if (gap_in >= cfg_gap_ff) begin
               tick_in = '0;
               gap_in  = '0;
               if (sdone_in >= cfg_count_ff) begin
                  phase_in = PH_IDLE;
                  tk_end   = 1'b1;
               end else begin
                  phase_in = PH_TRIG_LOW;
               end
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   urav_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (num_op_ff),
      .divisor  (den_op_ff),
      .quotient (div_q),
      .status   (div_stat)
   );

   assign dist_sat    = (div_q > urav_pkg::NUM_W'(urav_pkg::DIST_MAX))
                        ? urav_pkg::DIST_W'(urav_pkg::DIST_MAX)
                        : div_q[urav_pkg::DIST_W-1:0];
   assign q_le_thresh = div_q <= urav_pkg::NUM_W'(cfg_thresh_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         tick_ff       <= '0;
         gap_ff        <= '0;
         pw_ff         <= '0;
         sdone_ff      <= '0;
         vcnt_ff       <= '0;
         sum_ff        <= '0;
         seq_ff        <= SQ_IDLE;
         div_start_ff  <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         if (rsp_tvalid_ff && rsp_tready) rsp_tvalid_ff <= 1'b0;
         case (seq_ff)
            SQ_IDLE: begin
               if (req_accept) begin
                  phase_ff <= phase_in;
                  tick_ff  <= tick_in;
                  gap_ff   <= gap_in;
                  pw_ff    <= pw_in;
                  sdone_ff <= sdone_in;
                  vcnt_ff  <= vcnt_in;
                  sum_ff   <= sum_in;
                  if (tk_end && vcnt_in != 8'd0) begin
                     seq_ff <= SQ_NUM_CM;
                  end else begin
                     rsp_tvalid_ff <= 1'b1;
                     rsp_tdata_ff  <= {2'b00, (tk_end ? vcnt_in : 8'd0), 1'b0,
                                       tk_end, {urav_pkg::DIST_W{1'b0}}, tk_end,
                                       (!tk_end && phase_in != PH_IDLE), tk_trig};
                  end
               end
            end
            SQ_NUM_CM: begin
               num_op_ff <= urav_pkg::NUM_W'(sum_ff) * urav_pkg::NUM_W'(urav_pkg::CM_SCALE);
               seq_ff    <= SQ_DEN_CM;
            end
            SQ_DEN_CM: begin
               den_op_ff    <= urav_pkg::DEN_W'(vcnt_ff) * urav_pkg::DEN_W'(urav_pkg::CM_DIV);
               div_start_ff <= 1'b1;
               seq_ff       <= SQ_DIV_CM;
            end
            SQ_DIV_CM: begin
               if (div_stat.done) begin
                  det_ff <= q_le_thresh;
                  if (cfg_inch_ff) begin
                     seq_ff <= SQ_NUM_IN;
                  end else begin
                     rsp_tvalid_ff <= 1'b1;
                     rsp_tdata_ff  <= {2'b00, vcnt_ff, q_le_thresh, 1'b0, dist_sat,
                                       1'b1, 1'b0, 1'b0};
                     seq_ff        <= SQ_IDLE;
                  end
               end
            end
            SQ_NUM_IN: begin
               num_op_ff <= urav_pkg::NUM_W'(sum_ff) * urav_pkg::NUM_W'(urav_pkg::INCH_SCALE);
               seq_ff    <= SQ_DEN_IN;
            end
            SQ_DEN_IN: begin
               den_op_ff    <= urav_pkg::DEN_W'(vcnt_ff) * urav_pkg::DEN_W'(urav_pkg::INCH_DIV);
               div_start_ff <= 1'b1;
               seq_ff       <= SQ_DIV_IN;
            end
            SQ_DIV_IN: begin
               if (div_stat.done) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= {2'b00, vcnt_ff, det_ff, 1'b0, dist_sat,
                                    1'b1, 1'b0, 1'b0};
                  seq_ff        <= SQ_IDLE;
               end
            end
            default: seq_ff <= SQ_IDLE;
         endcase
      end
   end

   `URAV_ASSERT_NOW(a_no_take_while_dividing, seq_ff != SQ_IDLE, !req_tready, "tick taken during division")
   `URAV_ASSERT_NEXT(a_div_runs_after_start, div_start_ff, div_stat.busy, "divider did not start")
   `URAV_ASSERT_NOW(a_idle_counters_clear, phase_ff == PH_IDLE, tick_ff == '0 && gap_ff == '0, "idle with counters set")
   `URAV_ASSERT_NOW(a_done_not_busy, rsp_tvalid_ff && rsp_tdata_ff[2], !rsp_tdata_ff[1] && !rsp_tdata_ff[0], "done word marked busy")

endmodule

// ----- src/urav_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by both distance units.
module urav_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [urav_pkg::NUM_W-1:0]   dividend,
   input  logic [urav_pkg::DEN_W-1:0]   divisor,
   output logic [urav_pkg::NUM_W-1:0]   quotient,
   output urav_pkg::div_status_type     status
);

   logic [urav_pkg::NUM_W-1:0] work_ff, work_in;
   logic [urav_pkg::DEN_W-1:0] rem_ff, rem_in;
   logic [urav_pkg::DEN_W-1:0] den_ff;
   logic [urav_pkg::CNT_W-1:0] cnt_ff;
   logic                       busy_ff;
   logic                       done_ff;
   logic [urav_pkg::DEN_W:0]   rem_sh;
   logic [urav_pkg::DEN_W:0]   diff;
   logic                       fits;

   always_comb begin
      rem_sh  = {rem_ff, work_ff[urav_pkg::NUM_W-1]};
      diff    = rem_sh - {1'b0, den_ff};
      fits    = rem_sh >= {1'b0, den_ff};
      rem_in  = fits ? diff[urav_pkg::DEN_W-1:0] : rem_sh[urav_pkg::DEN_W-1:0];
      // quotient bits fill in from the bottom as dividend bits leave the top
      work_in = {work_ff[urav_pkg::NUM_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            work_ff <= dividend;
            den_ff  <= divisor;
            rem_ff  <= '0;
            cnt_ff  <= urav_pkg::CNT_W'(urav_pkg::NUM_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            work_ff <= work_in;
            rem_ff  <= rem_in;
            cnt_ff  <= cnt_ff - urav_pkg::CNT_W'(1);
            if (cnt_ff == urav_pkg::CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient    = work_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ----- verif/tb_ultrasonic_range_averager_top.sv -----
// Self-checking testbench for the ultrasonic range averager: tick stream, APB setup, scoreboard.
`timescale 1ns / 1ps

module tb_ultrasonic_range_averager_top;

   localparam int ECHO_TIMEOUT_US = 50000;
   localparam int TRIGGER_HIGH_US = 10;
   localparam int RANDOM_TICKS    = 1150;
   localparam int SETTLE_CYCLES   = 150;

   // result word, lowest bit last
   typedef struct packed {
      logic [1:0]                  spare;
      logic [7:0]                  valid_samples;
      logic                        detected;
      logic                        no_echo;
      logic [urav_pkg::DIST_W-1:0] distance_centi;
      logic                        done_res;
      logic                        busy_res;
      logic                        trigger_level;
   } range_word_type;

   typedef enum logic [2:0] {
      SONAR_IDLE,
      SONAR_TRIG_LOW,
      SONAR_TRIG_HIGH,
      SONAR_WAIT_LOW,
      SONAR_WAIT_HIGH,
      SONAR_PULSE,
      SONAR_GAP
   } sonar_phase_type;

   typedef enum logic {ROW_TICK, ROW_CSR} row_kind_type;
   typedef enum logic [1:0] {ECHO_LOW, ECHO_HIGH, ECHO_SENSOR} echo_src_type;

   // reps of zero: repeat until the run is over
   typedef struct {
      row_kind_type            kind;
      logic                    start;
      echo_src_type            src;
      int unsigned             reps;
      bit                      typed;
      range_word_type          want;
      urav_pkg::reg_index_type reg_idx;
      logic [31:0]             value;
   } plan_row_type;

   localparam range_word_type IDLE_WORD      = '0;
   localparam range_word_type EMPTY_RUN_WORD = '{done_res: 1'b1, no_echo: 1'b1, default: '0};

   logic                          clock       = 1'b0;
   logic                          reset       = 1'b1;
   logic                          req_tvalid  = 1'b0;
   logic                          req_tready;
   logic [7:0]                    req_tdata   = '0;   // [0] start_req, [1] echo_level
   logic                          rsp_tvalid;
   logic                          rsp_tready  = 1'b0;
   logic [31:0]                   rsp_tdata;          // [0] trigger_level, [1] busy_res,
                                                      // [2] done_res, [19:3] distance_centi,
                                                      // [20] no_echo, [21] detected,
                                                      // [29:22] valid_samples
   logic                          csr_psel    = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite  = 1'b0;
   logic [urav_pkg::ADDR_W-1:0]   csr_paddr   = '0;
   logic [31:0]                   csr_pwdata  = '0;
   logic [31:0]                   csr_prdata;
   logic                          csr_pready;

   // ranging model state and its copy of the registers
   sonar_phase_type               sonar_phase  = SONAR_IDLE;
   int unsigned                   tick_count   = 0;
   logic [15:0]                   gap_count    = '0;
   logic [15:0]                   pulse_width  = '0;
   logic [7:0]                    samples_done = '0;
   logic [7:0]                    valid_count  = '0;
   logic [urav_pkg::SUM_W-1:0]    width_sum    = '0;
   logic [7:0]                    cfg_count    = 8'd1;
   logic [15:0]                   cfg_gap      = '0;
   logic                          cfg_inch     = 1'b0;
   logic [urav_pkg::DIST_W-1:0]   cfg_thresh   = '0;

   // echo sensor plan for the current measurement
   int unsigned                   echo_stale   = 0;
   int unsigned                   echo_lead    = 0;
   int unsigned                   echo_hold    = 0;
   bit                            echo_noisy   = 1'b0;

   range_word_type                range_due[$];
   plan_row_type                  opening_plan[$];
   int unsigned                   burst_left   = 0;
   int unsigned                   sink_window  = 0;
   int unsigned                   sink_hold    = 0;
   bit                            sink_calm    = 1'b0;
   int                            mismatches   = 0;

   ultrasonic_range_averager_top #(
      .ECHO_TIMEOUT_US(ECHO_TIMEOUT_US),
      .TRIGGER_HIGH_US(TRIGGER_HIGH_US)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #5 clock = ~clock;

   // One microsecond tick of the ranging sequence.
   task automatic predict_tick(input logic start, input logic echo, output range_word_type res);
      logic            run_end;
      logic            meas_end;
      logic            meas_ok;
      logic            gap_over;
      longint unsigned cm;
      longint unsigned dist_val;
      run_end  = 1'b0;
      meas_end = 1'b0;
      meas_ok  = 1'b0;
      gap_over = 1'b0;
      res      = '0;
      if (sonar_phase == SONAR_IDLE && start) begin
         samples_done = '0;
         valid_count  = '0;
         width_sum    = '0;
         pulse_width  = '0;
         tick_count   = 0;
         gap_count    = '0;
         if (cfg_count == 0) run_end = 1'b1;
         else sonar_phase = SONAR_TRIG_LOW;
      end
      case (sonar_phase)
         SONAR_TRIG_LOW: begin
            tick_count++;
            if (tick_count >= urav_pkg::TRIG_LOW_TICKS) begin
               sonar_phase = SONAR_TRIG_HIGH;
               tick_count  = 0;
            end
         end
         SONAR_TRIG_HIGH: begin
            res.trigger_level = 1'b1;
            tick_count++;
            if (tick_count >= TRIGGER_HIGH_US) begin
               sonar_phase = SONAR_WAIT_LOW;
               tick_count  = 0;
            end
         end
         SONAR_WAIT_LOW, SONAR_WAIT_HIGH, SONAR_PULSE: begin
            tick_count++;
            case (sonar_phase)
               SONAR_WAIT_LOW: if (!echo) sonar_phase = SONAR_WAIT_HIGH;
               SONAR_WAIT_HIGH: begin
                  if (echo) begin
                     sonar_phase = SONAR_PULSE;
                     pulse_width = 16'd1;
                  end
               end
               default: begin
                  if (!echo) begin
                     meas_end = 1'b1;
                     meas_ok  = 1'b1;
                  end else if (pulse_width != 16'hFFFF) pulse_width++;
               end
            endcase
            // a falling edge on the last budget tick still counts
            if (!meas_end && tick_count >= ECHO_TIMEOUT_US) meas_end = 1'b1;
            if (meas_end) begin
               samples_done++;
               if (meas_ok) begin
                  valid_count++;
                  width_sum += urav_pkg::SUM_W'(pulse_width);
               end
               pulse_width = '0;
               tick_count  = 0;
               gap_count   = '0;
               if (cfg_gap == 0) gap_over = 1'b1;
               else sonar_phase = SONAR_GAP;
            end
         end
         SONAR_GAP: begin
            tick_count++;
            if (tick_count >= urav_pkg::TICKS_PER_MS) begin
               tick_count = 0;
               if (gap_count != 16'hFFFF) gap_count++;
            end
            if (gap_count >= cfg_gap) gap_over = 1'b1;
         end
         default: sonar_phase = SONAR_IDLE;
      endcase
      if (gap_over) begin
         tick_count = 0;
         gap_count  = '0;
         if (samples_done >= cfg_count) begin
            sonar_phase = SONAR_IDLE;
            run_end     = 1'b1;
         end else sonar_phase = SONAR_TRIG_LOW;
      end
      res.busy_res = !run_end && sonar_phase != SONAR_IDLE;
      if (run_end) begin
         res.done_res      = 1'b1;
         res.valid_samples = valid_count;
         if (valid_count == 0) res.no_echo = 1'b1;
         else begin
            cm = (64'(width_sum) * urav_pkg::CM_SCALE)
                 / (64'(valid_count) * urav_pkg::CM_DIV);
            if (cfg_inch) dist_val = (64'(width_sum) * urav_pkg::INCH_SCALE)
                                     / (64'(valid_count) * urav_pkg::INCH_DIV);
            else dist_val = cm;
            if (dist_val > urav_pkg::DIST_MAX) dist_val = urav_pkg::DIST_MAX;
            res.distance_centi = urav_pkg::DIST_W'(dist_val);
            res.detected       = cm <= cfg_thresh;
         end
      end
   endtask

   // Sensor echo for a target: at times a stale pulse, then a mostly short echo, or noise.
   task automatic sensor_echo(output logic echo);
      case (sonar_phase)
         SONAR_IDLE, SONAR_TRIG_LOW, SONAR_TRIG_HIGH: begin
            echo_stale = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
            echo_lead  = 0;
            echo_hold  = 0;
            echo_noisy = ($urandom_range(0, 9) == 0);
            echo       = echo_stale != 0;
         end
         SONAR_GAP: echo = 1'($urandom_range(0, 1));
         default: begin
            if (echo_noisy) echo = 1'($urandom_range(0, 1));
            else if (echo_stale != 0) begin
               echo = 1'b1;
               echo_stale--;
            end else begin
               if (echo_lead == 0 && echo_hold == 0 && sonar_phase != SONAR_PULSE) begin
                  echo_lead = $urandom_range(1, 6);
                  echo_hold = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 1200)
                                                          : $urandom_range(1, 40);
               end
               if (echo_lead != 0) begin
                  echo = 1'b0;
                  echo_lead--;
               end else if (echo_hold != 0) begin
                  echo = 1'b1;
                  echo_hold--;
               end else echo = 1'b0;
            end
         end
      endcase
   endtask

   // Predict one tick, then drive it in bursts with random gaps between them.
   task automatic send_tick(input logic start, input logic echo, input bit typed,
                            input range_word_type want);
      range_word_type pred;
      int unsigned    gap;
      predict_tick(start, echo, pred);
      range_due.push_back(typed ? want : pred);
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, echo, start};
      do @(posedge clock); while (!req_tready);
   endtask

   // Write one register once the block has answered every tick, then read it back.
   task automatic csr_write(input urav_pkg::reg_index_type idx, input logic [31:0] value);
      logic [31:0] readback;
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (range_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         urav_pkg::REG_SAMPLE_COUNT:  cfg_count  = value[7:0];
         urav_pkg::REG_SAMPLE_GAP_MS: cfg_gap    = value[15:0];
         urav_pkg::REG_UNIT_INCH:     cfg_inch   = value[0];
         default:                     cfg_thresh = value[urav_pkg::DIST_W-1:0];
      endcase
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== value) begin
         $display("%0t ns: register %s readback expected %0d got %0d",
                  $time, idx.name(), value, readback);
         mismatches++;
      end
   endtask

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want !== got) begin
         $display("%0t ns: %s expected %0d got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Receiver: calm stretches alternate with stretches of short stalls.
   always @(negedge clock) begin
      if (sink_window == 0) begin
         sink_calm   = ($urandom_range(0, 2) == 0);
         sink_window = $urandom_range(40, 300);
      end
      sink_window--;
      if (sink_hold != 0) begin
         sink_hold--;
         rsp_tready <= 1'b0;
      end else if (!sink_calm && $urandom_range(0, 3) == 0) begin
         sink_hold = $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else rsp_tready <= 1'b1;
   end

   always @(posedge clock) begin : watch_rsp
      range_word_type seen;
      range_word_type owed;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = rsp_tdata;
         if (range_due.size() == 0) begin
            $display("%0t ns: result word expected none got %h", $time, rsp_tdata);
            mismatches++;
         end else begin
            owed = range_due.pop_front();
            check_field("trigger_level", owed.trigger_level, seen.trigger_level);
            check_field("busy_res", owed.busy_res, seen.busy_res);
            check_field("done_res", owed.done_res, seen.done_res);
            check_field("distance_centi", owed.distance_centi, seen.distance_centi);
            check_field("no_echo", owed.no_echo, seen.no_echo);
            check_field("detected", owed.detected, seen.detected);
            check_field("valid_samples", owed.valid_samples, seen.valid_samples);
         end
      end
   end

   initial begin
      #60_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      plan_row_type            row;
      int unsigned             done_reps;
      int unsigned             run_ticks;
      logic                    start;
      logic                    echo;
      bit                      counted;
      urav_pkg::reg_index_type pick;
      logic [31:0]             value;

      // idle after reset, then one run on reset settings
      opening_plan.push_back('{ROW_TICK, 1'b0, ECHO_LOW, 3, 1'b1, IDLE_WORD,
                               urav_pkg::REG_SAMPLE_COUNT, 0});
      opening_plan.push_back('{ROW_TICK, 1'b1, ECHO_SENSOR, 0, 1'b0, IDLE_WORD,
                               urav_pkg::REG_SAMPLE_COUNT, 0});
      // zero sample count answers on the start tick
      opening_plan.push_back('{ROW_CSR, 1'b0, ECHO_LOW, 0, 1'b0, IDLE_WORD,
                               urav_pkg::REG_SAMPLE_COUNT, 0});
      opening_plan.push_back('{ROW_TICK, 1'b1, ECHO_LOW, 1, 1'b1, EMPTY_RUN_WORD,
                               urav_pkg::REG_SAMPLE_COUNT, 0});
      opening_plan.push_back('{ROW_TICK, 1'b1, ECHO_HIGH, 1, 1'b1, EMPTY_RUN_WORD,
                               urav_pkg::REG_SAMPLE_COUNT, 0});
      opening_plan.push_back('{ROW_CSR, 1'b0, ECHO_LOW, 0, 1'b0, IDLE_WORD,
                               urav_pkg::REG_SAMPLE_GAP_MS, 65535});
      opening_plan.push_back('{ROW_TICK, 1'b0, ECHO_HIGH, 2, 1'b1, IDLE_WORD,
                               urav_pkg::REG_SAMPLE_COUNT, 0});
      opening_plan.push_back('{ROW_CSR, 1'b0, ECHO_LOW, 0, 1'b0, IDLE_WORD,
                               urav_pkg::REG_SAMPLE_GAP_MS, 0});
      // full-length run with start held high, including on the done tick
      opening_plan.push_back('{ROW_CSR, 1'b0, ECHO_LOW, 0, 1'b0, IDLE_WORD,
                               urav_pkg::REG_SAMPLE_COUNT, 255});
      opening_plan.push_back('{ROW_CSR, 1'b0, ECHO_LOW, 0, 1'b0, IDLE_WORD,
                               urav_pkg::REG_THRESHOLD, 100000});
      opening_plan.push_back('{ROW_TICK, 1'b1, ECHO_SENSOR, 0, 1'b0, IDLE_WORD,
                               urav_pkg::REG_SAMPLE_COUNT, 0});
      // echo falling on the last budget tick, then a stuck-high echo that times out
      opening_plan.push_back('{ROW_CSR, 1'b0, ECHO_LOW, 0, 1'b0, IDLE_WORD,
                               urav_pkg::REG_UNIT_INCH, 1});
      opening_plan.push_back('{ROW_CSR, 1'b0, ECHO_LOW, 0, 1'b0, IDLE_WORD,
                               urav_pkg::REG_SAMPLE_COUNT, 2});
      opening_plan.push_back('{ROW_TICK, 1'b1, ECHO_LOW, 13, 1'b0, IDLE_WORD,
                               urav_pkg::REG_SAMPLE_COUNT, 0});
      opening_plan.push_back('{ROW_TICK, 1'b0, ECHO_HIGH, ECHO_TIMEOUT_US - 2, 1'b0, IDLE_WORD,
                               urav_pkg::REG_SAMPLE_COUNT, 0});
      opening_plan.push_back('{ROW_TICK, 1'b0, ECHO_LOW, 1, 1'b0, IDLE_WORD,
                               urav_pkg::REG_SAMPLE_COUNT, 0});
      opening_plan.push_back('{ROW_TICK, 1'b0, ECHO_HIGH, 0, 1'b0, IDLE_WORD,
                               urav_pkg::REG_SAMPLE_COUNT, 0});
      // one ms gap, with the sample count cut while the gap runs
      opening_plan.push_back('{ROW_CSR, 1'b0, ECHO_LOW, 0, 1'b0, IDLE_WORD,
                               urav_pkg::REG_SAMPLE_GAP_MS, 1});
      opening_plan.push_back('{ROW_CSR, 1'b0, ECHO_LOW, 0, 1'b0, IDLE_WORD,
                               urav_pkg::REG_SAMPLE_COUNT, 3});
      opening_plan.push_back('{ROW_CSR, 1'b0, ECHO_LOW, 0, 1'b0, IDLE_WORD,
                               urav_pkg::REG_UNIT_INCH, 0});
      opening_plan.push_back('{ROW_CSR, 1'b0, ECHO_LOW, 0, 1'b0, IDLE_WORD,
                               urav_pkg::REG_THRESHOLD, 3000});
      opening_plan.push_back('{ROW_TICK, 1'b1, ECHO_LOW, 13, 1'b0, IDLE_WORD,
                               urav_pkg::REG_SAMPLE_COUNT, 0});
      opening_plan.push_back('{ROW_TICK, 1'b0, ECHO_HIGH, 20, 1'b0, IDLE_WORD,
                               urav_pkg::REG_SAMPLE_COUNT, 0});
      opening_plan.push_back('{ROW_TICK, 1'b0, ECHO_LOW, 300, 1'b0, IDLE_WORD,
                               urav_pkg::REG_SAMPLE_COUNT, 0});
      opening_plan.push_back('{ROW_CSR, 1'b0, ECHO_LOW, 0, 1'b0, IDLE_WORD,
                               urav_pkg::REG_SAMPLE_COUNT, 1});
      opening_plan.push_back('{ROW_TICK, 1'b0, ECHO_LOW, 0, 1'b0, IDLE_WORD,
                               urav_pkg::REG_SAMPLE_COUNT, 0});
      opening_plan.push_back('{ROW_CSR, 1'b0, ECHO_LOW, 0, 1'b0, IDLE_WORD,
                               urav_pkg::REG_SAMPLE_GAP_MS, 0});
      opening_plan.push_back('{ROW_CSR, 1'b0, ECHO_LOW, 0, 1'b0, IDLE_WORD,
                               urav_pkg::REG_THRESHOLD, 0});

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (opening_plan[i]) begin
         row = opening_plan[i];
         if (row.kind == ROW_CSR) csr_write(row.reg_idx, row.value);
         else begin
            done_reps = 0;
            do begin
               case (row.src)
                  ECHO_LOW:  echo = 1'b0;
                  ECHO_HIGH: echo = 1'b1;
                  default:   sensor_echo(echo);
               endcase
               send_tick(row.start, echo, row.typed, row.want);
               done_reps++;
            end while (row.reps == 0 ? sonar_phase != SONAR_IDLE : done_reps < row.reps);
         end
      end

      // mostly well-formed runs with random settings; start requests also land mid-run
      run_ticks = 0;
      while (run_ticks < RANDOM_TICKS) begin
         if (sonar_phase == SONAR_IDLE) begin
            if ($urandom_range(0, 4) == 0) begin
               pick = urav_pkg::reg_index_type'($urandom_range(0, 3));
               case (pick)
                  urav_pkg::REG_SAMPLE_COUNT: begin
                     if (cfg_gap != 0) value = $urandom_range(0, 3);
                     else if ($urandom_range(0, 7) == 0) value = $urandom_range(6, 40);
                     else value = $urandom_range(0, 5);
                  end
                  urav_pkg::REG_SAMPLE_GAP_MS:
                     value = ($urandom_range(0, 7) == 0 && cfg_count <= 3) ? 1 : 0;
                  urav_pkg::REG_UNIT_INCH: value = $urandom_range(0, 1);
                  default: value = $urandom_range(0, 1) ? $urandom_range(0, 8000)
                                                        : $urandom_range(0, 100000);
               endcase
               csr_write(pick, value);
            end
            start = ($urandom_range(0, 3) != 0);
         end else start = ($urandom_range(0, 3) == 0);
         counted = start || (sonar_phase != SONAR_IDLE && sonar_phase != SONAR_GAP);
         sensor_echo(echo);
         send_tick(start, echo, 1'b0, IDLE_WORD);
         if (counted) run_ticks++;
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (range_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
